>>> design/ksm_pkg.sv
// Package for the key set membership table.
// Holds field widths, parameter defaults, the operation codes and the
// command and status structs that join the controller and the datapath.
package ksm_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_BITS_DEF = 20;
	localparam int KEY_W        = 20;
	localparam int KIND_W       = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_TEST   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
	} ksm_cmd_t;

	typedef struct packed {
		logic last;
		logic out_busy;
	} ksm_sts_t;

endpackage

>>> design/ksm_ctrl.sv
// Controller state machine for the key set membership table.
// Depends on ksm_pkg; drives ksm_cmd_t to the datapath and reads ksm_sts_t.
module ksm_ctrl import ksm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  ksm_sts_t sts,
	output ksm_cmd_t cmd,
	output logic     idle
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.last) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (!sts.out_busy) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		idle = 1'b0;
		case (state_q)
			ST_IDLE: begin
				idle      = 1'b1;
				cmd.start = in_valid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_FINISH: begin
				cmd.commit = !sts.out_busy;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> design/ksm_dpath.sv
// Datapath for the key set membership table: key memory, entry valid flags,
// scan counter, match and free-slot tracking, and the result register.
// Depends on ksm_pkg; commanded by ksm_ctrl.
module ksm_dpath import ksm_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ksm_cmd_t          cmd,
	output ksm_sts_t          sts,
	input  logic [KIND_W-1:0] kind,
	input  logic [KEY_W-1:0]  key,
	input  logic              out_stall,
	output logic              out_valid,
	output logic              was_present,
	output logic              add_dropped
);

	localparam int IDX_W = $clog2(CAPACITY);

	logic [KEY_BITS-1:0] mem [CAPACITY];
	logic [CAPACITY-1:0] valid_q;

	logic [KIND_W-1:0]   kind_q;
	logic [KEY_BITS-1:0] key_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    idx_s1;
	logic                val_s1;
	logic [KEY_BITS-1:0] rdata_s1;
	logic                live_s1;
	logic                hit_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic                free_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic                out_valid_q;
	logic                was_present_q;
	logic                add_dropped_q;

	logic is_add;
	logic is_remove;
	logic wr_en;
	logic clr_en;

	assign is_add     = (kind_q == KIND_ADD);
	assign is_remove  = (kind_q == KIND_REMOVE);
	assign wr_en      = cmd.commit && is_add && !hit_q && free_q;
	assign clr_en     = cmd.commit && is_remove && hit_q;

	assign sts = '{
		last:     (idx_q == IDX_W'(CAPACITY - 1)),
		out_busy: (out_valid_q && out_stall)
	};

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			rdata_s1 <= mem[idx_q];
			live_s1  <= valid_q[idx_q];
		end
		if (wr_en) begin
			mem[free_idx_q] <= key_q;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (cmd.start) begin
			kind_q <= kind;
			key_q  <= KEY_BITS'(key);
			idx_q  <= '0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (cmd.scan) begin
				idx_q <= idx_q + 1'b1;
			end
			if (val_s1 && live_s1 && rdata_s1 == key_q && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
			end
			if (val_s1 && !live_s1 && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end
		end
		if (cmd.commit) begin
			was_present_q <= hit_q;
			add_dropped_q <= is_add && !hit_q && !free_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			val_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			val_s1 <= cmd.scan;
			if (wr_en) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (clr_en) begin
				valid_q[hit_idx_q] <= 1'b0;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign was_present = was_present_q;
	assign add_dropped = add_dropped_q;

`ifndef SYNTHESIS
	a_commit_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("commit did not load the result register");

	a_commit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid_q && out_stall))
		else $error("commit overwrote a stalled result");

	a_drop_not_present: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(was_present_q && add_dropped_q))
		else $error("dropped add reported a present key");

	a_remove_clears: assert property (@(posedge clk) disable iff (!arst_n)
		clr_en |=> !valid_q[$past(hit_idx_q)])
		else $error("remove left the entry valid");

	a_add_sets: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> valid_q[$past(free_idx_q)])
		else $error("add did not mark the entry valid");
`endif

endmodule

>>> design/key_set_membership_table.sv
// Channel  Handshake             Payload
// in       in_valid / in_stall    kind[1:0], key[19:0]
// out      out_valid / out_stall  was_present, add_dropped
//
// Each item passes through accept, one key memory read per entry, a compare of
// the last entry, and the commit. The single read port of the key memory,
// swept one entry per cycle, bounds how fast an item goes through.
// Reset clears the entry valid flags at once; the block is ready right after.
// A stalled result holds the commit; no new item is accepted until it is done.
// Top level of the key set membership table; depends on ksm_pkg, ksm_ctrl
// and ksm_dpath.
module key_set_membership_table import ksm_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [KIND_W-1:0] kind,
	input  logic [KEY_W-1:0]  key,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              was_present,
	output logic              add_dropped
);

	ksm_cmd_t cmd;
	ksm_sts_t sts;
	logic     idle;

	assign in_stall = !idle;

	ksm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.idle     (idle)
	);

	ksm_dpath #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (kind),
		.key         (key),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.was_present (was_present),
		.add_dropped (add_dropped)
	);

endmodule
